@@ src/aes_enc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES encryption package
// Shared constants, the S-box table and GF(2^8) helpers for the AES pipeline.
// ----------------------------------------------------------------------------
package aes_enc_pkg;

  localparam int unsigned KEY_WORDS_DEF = 4;
  localparam int unsigned BLOCK_W       = 128;
  localparam int unsigned HALF_W        = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned KEY_REGS      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;

  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [WORD_W-1:0] sbox_subst(input logic [WORD_W-1:0] w);
    sbox_subst = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

@@ src/aes_block_encrypt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES block encryption
// Pipelined AES encryption of 128-bit blocks under a configurable key.
// ----------------------------------------------------------------------------
// One block enters per cycle while in_stall_o is low; a result passes through
// one stage for the initial key addition and one per round, the last stage
// being the output register. A stalled output holds only the stages behind it
// that are full. After reset and after every key register write, the round
// keys are rebuilt one word per cycle, 4 * (KEY_WORDS + 7) words in all (44
// for a 128-bit key), while in_stall_o stays high.
module aes_block_encrypt #(
  parameter int unsigned KEY_WORDS = aes_enc_pkg::KEY_WORDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [aes_enc_pkg::HALF_W-1:0]    block_high_i,
  input  wire logic [aes_enc_pkg::HALF_W-1:0]    block_low_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [aes_enc_pkg::HALF_W-1:0]    cipher_high_o,
  output logic      [aes_enc_pkg::HALF_W-1:0]    cipher_low_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [aes_enc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]                       cfg_data_i
);
  import aes_enc_pkg::*;

  localparam int unsigned NR    = KEY_WORDS + 6;
  localparam int unsigned DEPTH = 4 * (NR + 1);

  logic [KEY_REGS-1:0][63:0] key_q;
  logic                      cfg_wr, key_start, busy;
  logic [DEPTH-1:0][31:0]    rk;
  logic [NR:0]               valid_q;
  logic [BLOCK_W-1:0]        data_q [NR+1];
  logic [BLOCK_W-1:0]        round_out [NR+1];
  logic [NR+1:0]             adv;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    key_start = 1'b0;
    unique case (cfg_index_i) inside
      REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31: key_start = cfg_wr;
      default:                                                 key_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_start) begin
      key_q[cfg_index_i[1:0]] <= cfg_data_i;
    end
  end

  aes_enc_key_expand #(.KEY_WORDS(KEY_WORDS)) u_key_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (key_start),
    .key_i   (key_q),
    .busy_o  (busy),
    .rk_o    (rk)
  );

  always_comb begin
    adv[NR+1] = !out_stall_i;
    for (int k = NR; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_stall_o    = busy || !adv[0];
  assign round_out[0]  = {block_high_i, block_low_i} ^ {rk[0], rk[1], rk[2], rk[3]};

  for (genvar r = 1; r <= NR; r++) begin : g_round
    aes_enc_round #(.LAST_ROUND(r == NR)) u_round (
      .state_i (data_q[r-1]),
      .key_i   ({rk[4*r], rk[4*r+1], rk[4*r+2], rk[4*r+3]}),
      .state_o (round_out[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i && !in_stall_o;
      end
      for (int k = 1; k <= NR; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i && !in_stall_o) begin
      data_q[0] <= round_out[0];
    end
    for (int k = 1; k <= NR; k++) begin
      if (adv[k] && valid_q[k-1]) begin
        data_q[k] <= round_out[k];
      end
    end
  end

  assign out_valid_o   = valid_q[NR];
  assign cipher_high_o = data_q[NR][BLOCK_W-1:HALF_W];
  assign cipher_low_o  = data_q[NR][HALF_W-1:0];

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("input accepted during key expansion");

  a_key_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_start |=> busy)
    else $error("key write did not start expansion");

  a_no_accept_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && !adv[1]) |-> in_stall_o)
    else $error("first stage overwritten while held");
`endif

endmodule
`default_nettype wire

@@ src/aes_enc_key_expand.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one round-key word per cycle while busy, from the key registers into
// a bank of round-key registers, restarting on every start request.
// ----------------------------------------------------------------------------
module aes_enc_key_expand #(
  parameter int unsigned KEY_WORDS = aes_enc_pkg::KEY_WORDS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  input  wire logic [aes_enc_pkg::KEY_REGS-1:0][63:0]  key_i,
  output logic                                         busy_o,
  output logic [4*(KEY_WORDS+7)-1:0][31:0]             rk_o
);
  import aes_enc_pkg::*;

  localparam int unsigned DEPTH = 4 * (KEY_WORDS + 7);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned MOD_W = $clog2(KEY_WORDS);

  logic                    busy_q, busy_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [MOD_W-1:0]        mod_q, mod_d;
  logic [7:0]              rcon_q, rcon_d;
  logic [WORD_W-1:0]       win_q [KEY_WORDS];
  logic [WORD_W-1:0]       rk_q  [DEPTH];
  logic [WORD_W-1:0]       prev, temp, new_word;
  logic [63:0]             key_reg;
  logic                    seeding;

  assign seeding = 32'(idx_q) < KEY_WORDS;
  assign key_reg = key_i[idx_q[2:1]];
  assign prev    = win_q[KEY_WORDS-1];

  always_comb begin
    temp   = prev;
    rcon_d = rcon_q;
    if (!seeding && mod_q == '0) begin
      temp   = sbox_subst({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
      rcon_d = xtime(rcon_q);
    end else if (!seeding && KEY_WORDS > 6 && 32'(mod_q) == 32'd4) begin
      temp = sbox_subst(prev);
    end
    if (seeding) begin
      new_word = idx_q[0] ? key_reg[31:0] : key_reg[63:32];
    end else begin
      new_word = win_q[0] ^ temp;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    mod_d  = mod_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      mod_d  = '0;
    end else if (busy_q) begin
      idx_d  = idx_q + 1'b1;
      mod_d  = (32'(mod_q) == KEY_WORDS - 1) ? '0 : mod_q + 1'b1;
      if (32'(idx_q) == DEPTH - 1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      mod_q  <= '0;
      rcon_q <= RCON_INIT;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      mod_q  <= mod_d;
      if (start_i) begin
        rcon_q <= RCON_INIT;
      end else if (busy_q) begin
        rcon_q <= rcon_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      rk_q[idx_q] <= new_word;
      for (int k = 0; k < KEY_WORDS - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[KEY_WORDS-1] <= new_word;
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      rk_o[k] = rk_q[k];
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

@@ src/aes_enc_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES round
// One cipher round: SubBytes, ShiftRows, MixColumns (skipped in the last
// round) and AddRoundKey.
// ----------------------------------------------------------------------------
module aes_enc_round #(
  parameter bit LAST_ROUND = 1'b0
) (
  input  wire logic [aes_enc_pkg::BLOCK_W-1:0] state_i,
  input  wire logic [aes_enc_pkg::BLOCK_W-1:0] key_i,
  output logic      [aes_enc_pkg::BLOCK_W-1:0] state_o
);
  import aes_enc_pkg::*;

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];
  logic [7:0] all_x;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s[k] = state_i[BLOCK_W-1-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all_x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int r = 0; r < 4; r++) begin
        m[4*c+r] = LAST_ROUND ? t[4*c+r]
                 : t[4*c+r] ^ all_x ^ xtime(t[4*c+r] ^ t[4*c+(r+1)%4]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      state_o[BLOCK_W-1-8*k -: 8] = m[k] ^ key_i[BLOCK_W-1-8*k -: 8];
    end
  end

endmodule
`default_nettype wire
